>>> hw/rtl/mts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Melody tone sequencer package
// Shared types, codes and the note table of the melody tone sequencer.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int NOTE_COUNT = 42;
    localparam int IDX_W      = 6;
    localparam int TICK_W     = 32;
    localparam int LEN_W      = 6;
    localparam int PERIOD_W   = 8;

    localparam logic [LEN_W-1:0] DUR_SHORT = 6'd15;
    localparam logic [LEN_W-1:0] DUR_LONG  = 6'd40;

    // Tone periods in 4 us units.
    localparam logic [PERIOD_W-1:0] P_C6 = 8'd238;
    localparam logic [PERIOD_W-1:0] P_D6 = 8'd212;
    localparam logic [PERIOD_W-1:0] P_E6 = 8'd189;
    localparam logic [PERIOD_W-1:0] P_F6 = 8'd179;
    localparam logic [PERIOD_W-1:0] P_G6 = 8'd159;
    localparam logic [PERIOD_W-1:0] P_A6 = 8'd142;

    localparam logic [PERIOD_W-1:0] NOTE_PERIOD [NOTE_COUNT] = '{
        P_C6, P_C6, P_G6, P_G6, P_A6, P_A6, P_G6,
        P_F6, P_F6, P_E6, P_E6, P_D6, P_D6, P_C6,
        P_G6, P_G6, P_F6, P_F6, P_E6, P_E6, P_D6,
        P_G6, P_G6, P_F6, P_F6, P_E6, P_E6, P_D6,
        P_C6, P_C6, P_G6, P_G6, P_A6, P_A6, P_G6,
        P_F6, P_F6, P_E6, P_E6, P_D6, P_D6, P_C6
    };

    // The last note of every phrase of seven is held long.
    localparam logic [NOTE_COUNT-1:0] NOTE_LONG_MASK = 42'h20408102040;

    localparam logic [1:0] ACT_STEP  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_START   = 4'b0010,
        MODE_PLAYING = 4'b0100,
        MODE_STOP    = 4'b1000
    } seq_mode_t;

    typedef enum logic [2:0] {
        PH_START = 3'b001,
        PH_PLAY  = 3'b010,
        PH_REST  = 3'b100
    } note_phase_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [TICK_W-1:0] now;
        logic              halted;
    } item_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] tone_period;
        logic                sounder_on;
        logic                busy_res;
    } result_t;

    function automatic logic [PERIOD_W-1:0] note_period(input logic [IDX_W-1:0] idx);
        logic [PERIOD_W-1:0] p;
        p = '0;
        if (idx < IDX_W'(NOTE_COUNT)) begin
            p = NOTE_PERIOD[idx];
        end
        return p;
    endfunction

    function automatic logic [LEN_W-1:0] note_length(input logic [IDX_W-1:0] idx);
        logic [LEN_W-1:0] d;
        d = '0;
        if (idx < IDX_W'(NOTE_COUNT)) begin
            d = NOTE_LONG_MASK[idx] ? DUR_LONG : DUR_SHORT;
        end
        return d;
    endfunction

endpackage

>>> hw/rtl/mts_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Melody tone sequencer input register
// Holds one input beat until the sequencer core consumes it.
// ----------------------------------------------------------------------------
module mts_in_reg import mts_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  advance,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // A held beat that leaves this cycle frees the register for the next one.
    // Nothing is taken while reset is held.
    assign s_ready    = aresetn && (!valid_reg || advance);
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> hw/rtl/mts_seq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Melody tone sequencer core
// Sequencer state and its update for one beat, with the result it yields.
// ----------------------------------------------------------------------------
module mts_seq_core import mts_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  item_t   item,
    input  logic    loop_mode,
    output result_t result
);

    seq_mode_t           mode_reg,    mode_next;
    note_phase_t         phase_reg,   phase_next;
    logic [IDX_W-1:0]    idx_reg,     idx_next;
    logic [TICK_W-1:0]   start_reg,   start_next;
    logic [LEN_W-1:0]    len_reg,     len_next;
    logic [PERIOD_W-1:0] period_reg,  period_next;
    logic                sounder_reg, sounder_next;

    logic [TICK_W-1:0] elapsed;
    logic              expired;
    logic [IDX_W-1:0]  idx_inc;

    always_comb begin
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        start_next   = start_reg;
        len_next     = len_reg;
        period_next  = period_reg;
        sounder_next = sounder_reg;
        elapsed      = '0;
        expired      = 1'b0;
        idx_inc      = '0;

        case (item.action)
            ACT_START: begin
                mode_next = MODE_START;
            end
            ACT_STOP: begin
                mode_next = MODE_STOP;
            end
            ACT_STEP: begin
                if (!item.halted) begin
                    if (mode_reg == MODE_STOP) begin
                        sounder_next = 1'b0;
                        mode_next    = MODE_IDLE;
                    end else if (mode_reg != MODE_IDLE) begin
                        if (mode_reg == MODE_START) begin
                            sounder_next = 1'b1;
                            idx_next     = '0;
                            mode_next    = MODE_PLAYING;
                            phase_next   = PH_START;
                        end
                        // A fresh note loads its tone and duration first.
                        if (phase_next != PH_PLAY && phase_next != PH_REST) begin
                            start_next  = item.now;
                            len_next    = note_length(idx_next);
                            period_next = note_period(idx_next);
                            phase_next  = PH_PLAY;
                        end
                        // Tick counts wrap, so elapsed time is a modular difference.
                        elapsed = item.now - start_next;
                        expired = elapsed >= {{(TICK_W-LEN_W){1'b0}}, len_next};
                        if (phase_next == PH_PLAY) begin
                            if (expired) begin
                                start_next  = item.now;
                                len_next    = note_length(idx_next);
                                period_next = '0;
                                phase_next  = PH_REST;
                            end
                        end else if (expired) begin
                            idx_inc = idx_next + 1'b1;
                            if (idx_inc >= IDX_W'(NOTE_COUNT)) begin
                                idx_next = '0;
                                if (!loop_mode) begin
                                    mode_next = MODE_STOP;
                                end
                            end else begin
                                idx_next = idx_inc;
                            end
                            phase_next = PH_START;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            phase_reg   <= PH_START;
            idx_reg     <= '0;
            start_reg   <= '0;
            len_reg     <= '0;
            period_reg  <= '0;
            sounder_reg <= 1'b0;
        end else if (advance) begin
            mode_reg    <= mode_next;
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            start_reg   <= start_next;
            len_reg     <= len_next;
            period_reg  <= period_next;
            sounder_reg <= sounder_next;
        end
    end

    assign result.tone_period = period_next;
    assign result.sounder_on  = sounder_next;
    assign result.busy_res    = (mode_next != MODE_IDLE);

endmodule

>>> hw/rtl/mts_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Melody tone sequencer output register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module mts_out_reg import mts_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result,
    output logic    free,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign free       = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

>>> hw/rtl/melody_tone_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Melody tone sequencer
// Buzzer melody sequencer: start, stop and step beats drive a 42-note tune.
//
//   Channel  Direction  Contents
//   s_       in         tuser: action; tdata: now, halted
//   m_       out        tdata: tone_period, sounder_on, busy_res
//   cfg_     in         loop_mode write, no read-back
//
// One beat per cycle while the result side keeps taking beats; each beat
// yields one result beat, presented once the input register has taken it
// and the state update has loaded it into the result register. Reset is
// synchronous and clears the sequencer to idle with the sounder off. A
// stalled result holds the input register, which in turn lowers s_tready.
// ----------------------------------------------------------------------------
module melody_tone_sequencer_unit import mts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,     // loop_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,       // [1:0] action
    input  logic [39:0] s_tdata,       // [31:0] now, [32] halted, [39:33] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata        // [7:0] tone_period, [8] sounder_on,
                                       // [9] busy_res, [15:10] zero
);

    logic    loop_mode_reg;
    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    out_free;
    logic    advance;
    result_t result;
    result_t m_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            loop_mode_reg <= cfg_wdata;
        end
    end

    assign s_item.action = s_tuser;
    assign s_item.now    = s_tdata[TICK_W-1:0];
    assign s_item.halted = s_tdata[TICK_W];

    assign advance = item_valid && out_free;

    mts_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mts_seq_core u_seq_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (item),
        .loop_mode (loop_mode_reg),
        .result    (result)
    );

    mts_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .free     (out_free),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {6'd0, m_result.busy_res, m_result.sounder_on, m_result.tone_period};

endmodule

>>> bench/tone_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Melody tone sequencer result checker
// Watches the input and result channels of the melody tone sequencer. It
// keeps its own model of the sequencer, predicts one result beat for every
// accepted input beat and compares each result beat, field by field, with
// the oldest prediction.
// ----------------------------------------------------------------------------
module tone_result_checker import mts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [1:0]  s_tuser,       // [1:0] action
    input  logic [39:0] s_tdata,       // [31:0] now, [32] halted, [39:33] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,       // [7:0] tone_period, [8] sounder_on,
                                       // [9] busy_res, [15:10] zero
    output int          fault_count
);

    localparam logic [7:0] TONE_C = 8'd238;
    localparam logic [7:0] TONE_D = 8'd212;
    localparam logic [7:0] TONE_E = 8'd189;
    localparam logic [7:0] TONE_F = 8'd179;
    localparam logic [7:0] TONE_G = 8'd159;
    localparam logic [7:0] TONE_A = 8'd142;

    seq_mode_t   mode_r;
    note_phase_t phase_r;
    logic [5:0]  idx_r;
    logic [31:0] t0_r;
    logic [5:0]  len_r;
    logic [7:0]  per_r;
    logic        snd_r;
    logic        loop_r;

    result_t     owed_q[$];
    int          errors = 0;

    // The tune is six phrases of seven notes, sung in pairs with the seventh
    // note on its own. Phrases one and five match, as do two and six, and
    // three and four.
    function automatic logic [7:0] tune_period(input logic [5:0] i);
        logic [2:0] row;
        logic [1:0] slot;
        logic [7:0] p;
        row  = 3'(i / 7);
        slot = 2'((i % 7) / 2);
        p    = 8'd0;
        if (i < NOTE_COUNT) begin
            if (row == 3'd0 || row == 3'd4) begin
                case (slot)
                    2'd0:    p = TONE_C;
                    2'd1:    p = TONE_G;
                    2'd2:    p = TONE_A;
                    default: p = TONE_G;
                endcase
            end else if (row == 3'd1 || row == 3'd5) begin
                case (slot)
                    2'd0:    p = TONE_F;
                    2'd1:    p = TONE_E;
                    2'd2:    p = TONE_D;
                    default: p = TONE_C;
                endcase
            end else begin
                case (slot)
                    2'd0:    p = TONE_G;
                    2'd1:    p = TONE_F;
                    2'd2:    p = TONE_E;
                    default: p = TONE_D;
                endcase
            end
        end
        return p;
    endfunction

    function automatic logic [5:0] tune_length(input logic [5:0] i);
        logic [5:0] d;
        d = 6'd0;
        if (i < NOTE_COUNT) begin
            d = (i % 7 == 6) ? 6'd40 : 6'd15;
        end
        return d;
    endfunction

    task automatic advance_tune(input logic [31:0] now_t);
        logic [31:0] gone;
        if (mode_r == MODE_IDLE) begin
            return;
        end
        if (mode_r == MODE_STOP) begin
            snd_r  = 1'b0;
            mode_r = MODE_IDLE;
            return;
        end
        if (mode_r == MODE_START) begin
            snd_r   = 1'b1;
            idx_r   = 6'd0;
            mode_r  = MODE_PLAYING;
            phase_r = PH_START;
        end
        if (phase_r != PH_PLAY && phase_r != PH_REST) begin
            t0_r    = now_t;
            len_r   = tune_length(idx_r);
            per_r   = tune_period(idx_r);
            phase_r = PH_PLAY;
        end
        // Elapsed time wraps with the tick counter.
        gone = now_t - t0_r;
        if (phase_r == PH_PLAY) begin
            if (gone >= {26'd0, len_r}) begin
                t0_r    = now_t;
                len_r   = tune_length(idx_r);
                per_r   = 8'd0;
                phase_r = PH_REST;
            end
        end else if (gone >= {26'd0, len_r}) begin
            idx_r = idx_r + 6'd1;
            if (idx_r >= NOTE_COUNT) begin
                idx_r = 6'd0;
                if (!loop_r) begin
                    mode_r = MODE_STOP;
                end
            end
            phase_r = PH_START;
        end
    endtask

    task automatic log_fault(input string why, input result_t want, input result_t got);
        errors++;
        if (errors <= 10) begin
            $display("%0t ns %s: expected period %0d sounder %0b busy %0b,", $time, why,
                     want.tone_period, want.sounder_on, want.busy_res,
                     " got period %0d sounder %0b busy %0b",
                     got.tone_period, got.sounder_on, got.busy_res);
        end
    endtask

    always @(posedge aclk) begin : watch
        result_t     want;
        result_t     got;
        logic [31:0] now_t;
        if (!aresetn) begin
            mode_r  = MODE_IDLE;
            phase_r = PH_START;
            idx_r   = 6'd0;
            t0_r    = 32'd0;
            len_r   = 6'd0;
            per_r   = 8'd0;
            snd_r   = 1'b0;
            loop_r  = 1'b0;
            owed_q.delete();
        end else begin
            if (cfg_we) begin
                loop_r = cfg_wdata;
            end
            if (m_tvalid && m_tready) begin
                got.tone_period = m_tdata[7:0];
                got.sounder_on  = m_tdata[8];
                got.busy_res    = m_tdata[9];
                if (owed_q.size() == 0) begin
                    log_fault("result beat with nothing expected", '0, got);
                end else begin
                    want = owed_q.pop_front();
                    if (got.tone_period !== want.tone_period ||
                        got.sounder_on !== want.sounder_on ||
                        got.busy_res !== want.busy_res) begin
                        log_fault("result mismatch", want, got);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                now_t = s_tdata[31:0];
                if (s_tuser == ACT_START) begin
                    mode_r = MODE_START;
                end else if (s_tuser == ACT_STOP) begin
                    mode_r = MODE_STOP;
                end else if (s_tuser == ACT_STEP && !s_tdata[32]) begin
                    advance_tune(now_t);
                end
                want.tone_period = per_r;
                want.sounder_on  = snd_r;
                want.busy_res    = (mode_r != MODE_IDLE);
                owed_q.push_back(want);
            end
        end
        // Results still owed count against the run as well.
        fault_count <= errors + owed_q.size();
    end

endmodule

>>> bench/melody_tone_sequencer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Melody tone sequencer testbench
// Drives start, stop and step beats into the sequencer: a directed opening
// around note boundaries, tick wrap and request ordering, then phases that
// play the tune through with and without loop mode, and a noisy phase. Both
// channels idle at random and the result side holds off for long stretches.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module melody_tone_sequencer_unit_tb;
    import mts_pkg::*;

    // Well above the slowest correct run: about 450 beats with both sides
    // idling at random between beats, two long hold-offs and the drains.
    localparam int LIMIT = 100000;
    localparam int HOLD  = 40;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    int          fault_count;
    int          items_sent = 0;
    int          beats_got  = 0;
    int          cycles     = 0;
    logic        s_burst    = 1'b0;
    logic        m_burst    = 1'b0;
    logic [31:0] tick;

    always #10 aclk = ~aclk;

    melody_tone_sequencer_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    tone_result_checker CHK (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fault_count (fault_count)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("melody_tone_sequencer_unit: mismatch");
            $finish;
        end
    end

    task automatic send_beat(input logic [1:0] act, input logic [31:0] t, input logic h);
        int gap;
        gap = s_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'd0, h, t};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Waits until every result beat is back, then lets the pipeline empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (beats_got != items_sent) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_loop(input logic v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic play_phase(input int n, input logic loop_v, input int noise_pct);
        int          r;
        logic [31:0] d;
        set_loop(loop_v);
        send_beat(ACT_START, tick, 1'b0);
        for (int k = 0; k < n; k++) begin
            if (k % 40 == 0) begin
                s_burst = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < noise_pct) begin
                case ($urandom_range(0, 4))
                    0: send_beat(ACT_START, tick, 1'($urandom_range(0, 1)));
                    1: send_beat(ACT_STOP, tick, 1'($urandom_range(0, 1)));
                    2: send_beat(ACT_SPARE, $urandom(), 1'($urandom_range(0, 1)));
                    3: begin
                        tick = $urandom();
                        send_beat(ACT_STEP, tick, 1'b0);
                    end
                    default: send_beat(ACT_STEP, tick + $urandom_range(0, 50), 1'b1);
                endcase
            end else if (r == noise_pct) begin
                send_beat(ACT_START, tick, 1'b0);
            end else begin
                // Mostly long enough to end any phase; some land on the edges.
                r = $urandom_range(0, 99);
                if (r < 85) begin
                    d = $urandom_range(40, 300);
                end else if (r < 95) begin
                    d = ((r % 2 == 0) ? 32'd14 : 32'd39) + $urandom_range(0, 2);
                end else begin
                    d = $urandom_range(0, 3);
                end
                tick = tick + d;
                send_beat(ACT_STEP, tick, ($urandom_range(0, 99) < 3));
            end
        end
    endtask

    // Result side: random waits per beat, quiet stretches, and two long
    // hold-offs while the sender keeps offering so that the block backs up.
    initial begin : sink
        int gap;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (beats_got % 50 == 0) begin
                m_burst = ($urandom_range(0, 3) == 0);
            end
            if (beats_got == 60 || beats_got == 300) begin
                m_tready <= 1'b0;
                repeat (HOLD) @(posedge aclk);
            end
            gap = m_burst ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            beats_got++;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= ACT_STEP;
        s_tdata   <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_loop(1'b0);
        send_beat(ACT_STEP, 32'd0, 1'b0);
        send_beat(ACT_SPARE, 32'hFFFF_FFFF, 1'b1);
        // A stop while idle only takes effect on the next step.
        send_beat(ACT_STOP, 32'd0, 1'b0);
        send_beat(ACT_STEP, 32'd5, 1'b0);
        // Requests are still recorded while halted; halted steps do nothing.
        send_beat(ACT_START, 32'd0, 1'b1);
        send_beat(ACT_STEP, 32'd10, 1'b1);
        send_beat(ACT_STEP, 32'd10, 1'b0);
        send_beat(ACT_STEP, 32'd24, 1'b0);
        send_beat(ACT_STEP, 32'd25, 1'b0);
        send_beat(ACT_STEP, 32'd39, 1'b0);
        send_beat(ACT_STEP, 32'd40, 1'b0);
        send_beat(ACT_STEP, 32'd40, 1'b0);
        // Restart mid-tune, then time the first note across the tick wrap.
        send_beat(ACT_START, 32'd40, 1'b0);
        send_beat(ACT_STEP, 32'hFFFF_FFF8, 1'b0);
        send_beat(ACT_STEP, 32'd6, 1'b0);
        send_beat(ACT_STEP, 32'd7, 1'b0);
        send_beat(ACT_SPARE, 32'd7, 1'b0);
        // The later request of the two wins.
        send_beat(ACT_STOP, 32'd7, 1'b0);
        send_beat(ACT_START, 32'd7, 1'b0);
        send_beat(ACT_STEP, 32'd100, 1'b0);
        // Stopping keeps the last period that was loaded.
        send_beat(ACT_STOP, 32'd100, 1'b0);
        send_beat(ACT_STEP, 32'd100, 1'b0);
        send_beat(ACT_STEP, 32'd200, 1'b0);

        tick = $urandom();
        play_phase(160, 1'b1, 0);
        tick = 32'hFFFF_FF00;
        play_phase(150, 1'b0, 0);
        play_phase(80, 1'($urandom_range(0, 1)), 20);

        settle();
        if (fault_count == 0) begin
            $display("melody_tone_sequencer_unit: match");
        end else begin
            $display("melody_tone_sequencer_unit: mismatch");
        end
        $finish;
    end

endmodule
